[rtl/sha256_digest_engine_core_macros.svh]
// Assertion helpers shared by the SHA-256 engine RTL.
`ifndef SHA256_DIGEST_ENGINE_CORE_MACROS_SVH
`define SHA256_DIGEST_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SDE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha256 engine check failed");
`define SDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha256 engine check failed");
`else
`define SDE_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/sha256de_pkg.sv]
`default_nettype none
package sha256de_pkg;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_FILL = 6'd56;
  localparam logic [5:0] LAST_FILL = 6'd63;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Index 0 holds the first initial hash word.
  localparam hash_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

[rtl/sha256de_sched.sv]
`default_nettype none
// Sixteen-word window that first collects the block bytes and then, during the
// rounds, slides forward one expanded schedule word per cycle.
module sha256de_sched (
  input  wire logic               clk_i,
  input  wire logic               byte_en_i,
  input  wire logic [7:0]         byte_i,
  input  wire logic               step_i,
  output sha256de_pkg::word_t     w_o
);

  logic [511:0]        win_q;
  logic [511:0]        win_d;
  sha256de_pkg::word_t w_new;

  // Word j of the window sits at bits 511-32j down.
  assign w_o   = win_q[511:480];
  assign w_new = sha256de_pkg::small_sigma1(win_q[63:32]) + win_q[223:192] +
                 sha256de_pkg::small_sigma0(win_q[479:448]) + win_q[511:480];

  always_comb begin
    win_d = win_q;
    if (byte_en_i) begin
      win_d = {win_q[503:0], byte_i};
    end else if (step_i) begin
      win_d = {win_q[479:0], w_new};
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule
`default_nettype wire

[rtl/sha256de_round.sv]
`default_nettype none
// Working variables a..h and the shared round function, applied once a cycle.
module sha256de_round (
  input  wire logic                clk_i,
  input  wire logic                load_i,
  input  wire sha256de_pkg::hash_t init_i,
  input  wire logic                step_i,
  input  wire logic [5:0]          round_i,
  input  wire sha256de_pkg::word_t w_i,
  output sha256de_pkg::hash_t      vars_o
);

  sha256de_pkg::hash_t vars_q;
  sha256de_pkg::hash_t vars_d;
  sha256de_pkg::word_t t1;
  sha256de_pkg::word_t t2;
  sha256de_pkg::word_t ch;
  sha256de_pkg::word_t maj;

  assign vars_o = vars_q;

  always_comb begin
    ch  = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
    maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
    t1  = vars_q[7] + sha256de_pkg::big_sigma1(vars_q[4]) + ch +
          sha256de_pkg::ROUND_K[round_i] + w_i;
    t2  = sha256de_pkg::big_sigma0(vars_q[0]) + maj;
    vars_d = vars_q;
    if (load_i) begin
      vars_d = init_i;
    end else if (step_i) begin
      vars_d[7] = vars_q[6];
      vars_d[6] = vars_q[5];
      vars_d[5] = vars_q[4];
      vars_d[4] = vars_q[3] + t1;
      vars_d[3] = vars_q[2];
      vars_d[2] = vars_q[1];
      vars_d[1] = vars_q[0];
      vars_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    vars_q <= vars_d;
  end

endmodule
`default_nettype wire

[rtl/sha256_digest_engine_core.sv]
// Streaming SHA-256 hasher. Each absorb transfer takes one message byte; the
// 64th byte of a block also starts the compression, which runs one round per
// cycle on a single shared round unit and keeps the input stalled through all
// the rounds and the fold into the hash. A finish transfer pads the message one
// byte per cycle (0x80, zeros, then the 8 length bytes), compressing once or
// twice on the way, and then hands out the eight digest words, word 0 first,
// with last_word set on word 7. A finish therefore keeps the input stalled
// through the padding, the compressions and the digest output, stalls included.
// The next absorb may be taken while the final digest word still waits.
`default_nettype none
`include "sha256_digest_engine_core_macros.svh"
module sha256_digest_engine_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire sha256de_pkg::in_item_t   in_item_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output sha256de_pkg::out_item_t       out_item_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_ROUND,
    S_FOLD,
    S_OUT
  } state_e;

  state_e                  state_q;
  state_e                  ret_q;
  logic [5:0]              fill_q;
  logic [63:0]             total_q;
  logic [5:0]              round_q;
  logic [2:0]              word_q;
  logic                    first_q;
  sha256de_pkg::hash_t     chain_q;
  logic                    out_valid_q;
  sha256de_pkg::out_item_t out_item_q;

  logic                    accept;
  logic                    byte_en;
  logic [7:0]              byte_val;
  logic                    pad_done;
  logic                    start_cmp;
  sha256de_pkg::word_t     w_t;
  sha256de_pkg::hash_t     vars;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign pad_done    = !first_q && (fill_q == sha256de_pkg::LEN_FILL);
  assign start_cmp   = byte_en && (fill_q == sha256de_pkg::LAST_FILL);

  always_comb begin
    byte_en  = 1'b0;
    byte_val = in_item_i.data_byte;
    case (state_q)
      S_IDLE: begin
        byte_en = accept && (in_item_i.op == sha256de_pkg::OP_ABSORB);
      end
      S_PAD: begin
        byte_en  = !pad_done;
        byte_val = first_q ? sha256de_pkg::PAD_BYTE : 8'h00;
      end
      S_LEN: begin
        byte_en  = 1'b1;
        byte_val = total_q[63:56];
      end
      default: begin
        byte_en = 1'b0;
      end
    endcase
  end

  sha256de_sched u_sched (
    .clk_i     (clk_i),
    .byte_en_i (byte_en),
    .byte_i    (byte_val),
    .step_i    (state_q == S_ROUND),
    .w_o       (w_t)
  );

  sha256de_round u_round (
    .clk_i   (clk_i),
    .load_i  (start_cmp),
    .init_i  (chain_q),
    .step_i  (state_q == S_ROUND),
    .round_i (round_q),
    .w_i     (w_t),
    .vars_o  (vars)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      fill_q      <= '0;
      total_q     <= '0;
      round_q     <= '0;
      word_q      <= '0;
      first_q     <= 1'b0;
      chain_q     <= sha256de_pkg::INIT_H;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      if (byte_en) begin
        fill_q <= fill_q + 6'd1;
      end
      // The last byte of a block hands control to the rounds.
      if (start_cmp) begin
        round_q <= '0;
        state_q <= S_ROUND;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_item_i.op == sha256de_pkg::OP_ABSORB) begin
              total_q <= total_q + 64'd8;
              ret_q   <= S_IDLE;
            end else begin
              first_q <= 1'b1;
              state_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          first_q <= 1'b0;
          ret_q   <= S_PAD;
          if (pad_done) begin
            state_q <= S_LEN;
          end
        end
        S_LEN: begin
          total_q <= {total_q[55:0], 8'h00};
          ret_q   <= S_OUT;
          word_q  <= '0;
        end
        S_ROUND: begin
          round_q <= round_q + 6'd1;
          if (round_q == 6'd63) begin
            state_q <= S_FOLD;
          end
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            chain_q[i] <= chain_q[i] + vars[i];
          end
          state_q <= ret_q;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q            <= 1'b1;
            out_item_q.digest_word <= chain_q[word_q];
            out_item_q.word_index  <= word_q;
            out_item_q.last_word   <= (word_q == 3'd7);
            word_q                 <= word_q + 3'd1;
            if (word_q == 3'd7) begin
              state_q <= S_IDLE;
              chain_q <= sha256de_pkg::INIT_H;
              fill_q  <= '0;
              total_q <= '0;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `SDE_ASSERT_NEXT(a_finish_busy, clk_i, rst_ni,
    accept && (in_item_i.op == sha256de_pkg::OP_FINISH), in_stall_o)
  `SDE_ASSERT_NEXT(a_rounds_fold, clk_i, rst_ni,
    (state_q == S_ROUND) && (round_q == 6'd63), state_q == S_FOLD)
  `SDE_ASSERT_SAME(a_last_is_seven, clk_i, rst_ni,
    out_valid_o, out_item_o.last_word == (out_item_o.word_index == 3'd7))

endmodule
`default_nettype wire
